// File: hdl/pps_pkg.sv
// Package of the preemptive priority scheduler: sizes, codes, types and helper functions.
`default_nettype none
package pps_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TIME_BITS = 16;
	localparam int PRIO_BITS = 8;

	localparam int IDX_W  = $clog2(MAX_TASKS);
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int FLD_TW = 16;
	localparam int SLOT_W = 4;
	localparam int ID_W   = 8;
	localparam int FPRI_W = 8;
	localparam int TC_W   = 5;
	localparam int FC_W   = 5;
	localparam int ADDR_W = 3;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [PRIO_BITS-1:0] prio_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [FLD_TW-1:0]    ftime_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [ID_W-1:0]      id_t;
	typedef logic [FPRI_W-1:0]    fprio_t;
	typedef logic [TC_W-1:0]      tc_t;
	typedef logic [FC_W-1:0]      fc_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic REG_TASK_COUNT = 1'b0;

	localparam time_t TIME_MAX = '1;
	localparam fc_t   FC_MAX   = '1;

	typedef struct packed {
		logic       found;
		logic [1:0] pend;
		idx_t       slot;
		prio_t      prio;
		time_t      arrival;
		time_t      burst;
		time_t      remaining;
		id_t        task_id;
	} tok_t;

	typedef struct packed {
		logic  valid;
		idx_t  slot;
		id_t   task_id;
		time_t arrival;
		time_t burst;
		prio_t prio;
	} ld_t;

	typedef struct packed {
		logic  valid;
		idx_t  slot;
		time_t remaining;
		logic  done;
	} upd_t;

	function automatic logic slot_ok(slot_t s);
		return int'(s) < MAX_TASKS;
	endfunction

	function automatic idx_t to_idx(slot_t s);
		return IDX_W'(s);
	endfunction

	function automatic slot_t to_slot(idx_t i);
		return SLOT_W'(i);
	endfunction

	function automatic time_t to_time(ftime_t t);
		return TIME_BITS'(t);
	endfunction

	function automatic ftime_t to_ftime(time_t t);
		return FLD_TW'(t);
	endfunction

	function automatic prio_t to_prio(fprio_t p);
		return PRIO_BITS'(p);
	endfunction

	function automatic logic in_use(idx_t i, tc_t tc);
		return int'(i) < int'(tc);
	endfunction

endpackage
`default_nettype wire

// File: hdl/pps_in_if.sv
// Input channel of the scheduler: valid, ready and the fields of one input word.
`default_nettype none
interface pps_in_if;
	logic            valid;
	logic            ready;
	logic            cmd;
	pps_pkg::slot_t  slot;
	pps_pkg::id_t    task_id;
	pps_pkg::ftime_t arrival_time;
	pps_pkg::ftime_t burst_time;
	pps_pkg::fprio_t prio_level;

	modport source (output valid, cmd, slot, task_id, arrival_time, burst_time, prio_level,
		input ready);
	modport sink (input valid, cmd, slot, task_id, arrival_time, burst_time, prio_level,
		output ready);
endinterface
`default_nettype wire

// File: hdl/pps_out_if.sv
// Result channel of the scheduler: valid, ready and the fields of one result word.
`default_nettype none
interface pps_out_if;
	logic            valid;
	logic            ready;
	pps_pkg::ftime_t now_time;
	logic            busy_res;
	pps_pkg::slot_t  run_slot;
	pps_pkg::id_t    run_task_id;
	logic            task_finished;
	pps_pkg::ftime_t finish_time;
	pps_pkg::ftime_t turnaround_time;
	pps_pkg::ftime_t waiting_time;
	logic            all_finished;

	modport source (output valid, now_time, busy_res, run_slot, run_task_id, task_finished,
		finish_time, turnaround_time, waiting_time, all_finished, input ready);
	modport sink (input valid, now_time, busy_res, run_slot, run_task_id, task_finished,
		finish_time, turnaround_time, waiting_time, all_finished, output ready);
endinterface
`default_nettype wire

// File: hdl/pps_cell.sv
// One task slot of the scheduler chain: holds the slot and passes the best candidate onward.
`default_nettype none
module pps_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pps_pkg::idx_t  idx,
	input  wire pps_pkg::tc_t   tc,
	input  wire pps_pkg::time_t now,
	input  wire pps_pkg::ld_t   ld,
	input  wire pps_pkg::upd_t  upd,
	input  wire pps_pkg::tok_t  tok_in,
	output pps_pkg::tok_t       tok_out
);

	pps_pkg::time_t arrival_q;
	pps_pkg::time_t burst_q;
	pps_pkg::time_t remaining_q;
	pps_pkg::prio_t prio_q;
	pps_pkg::id_t   task_id_q;
	logic           done_q;
	pps_pkg::tok_t  tok_q;

	logic          live;
	logic          eligible;
	logic          better;
	pps_pkg::tok_t tok_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1;
		end else if (ld.valid && ld.slot == idx) begin
			done_q <= 1'b0;
		end else if (upd.valid && upd.slot == idx) begin
			done_q <= upd.done;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.valid && ld.slot == idx) begin
			arrival_q   <= ld.arrival;
			burst_q     <= ld.burst;
			remaining_q <= ld.burst;
			prio_q      <= ld.prio;
			task_id_q   <= ld.task_id;
		end else if (upd.valid && upd.slot == idx) begin
			remaining_q <= upd.remaining;
		end
	end

	always_comb begin
		live     = pps_pkg::in_use(idx, tc) && !done_q;
		eligible = live && (arrival_q <= now);
		better   = !tok_in.found || (prio_q < tok_in.prio) ||
			((prio_q == tok_in.prio) && (arrival_q < tok_in.arrival));
		tok_nxt  = tok_in;
		if (eligible && better) begin
			tok_nxt.found     = 1'b1;
			tok_nxt.slot      = idx;
			tok_nxt.prio      = prio_q;
			tok_nxt.arrival   = arrival_q;
			tok_nxt.burst     = burst_q;
			tok_nxt.remaining = remaining_q;
			tok_nxt.task_id   = task_id_q;
		end
		if (live && tok_in.pend != 2'd2) begin
			tok_nxt.pend = tok_in.pend + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// File: hdl/preemptive_priority_scheduler_top.sv
// Top level of the preemptive priority scheduler: slot chain, sequencer and register port.
//
// Channel  Direction  Handshake            Word
// req      in         valid/ready          cmd, slot, task_id, arrival, burst, priority
// res      out        valid/ready          times, running task, completion flags
// apb      in         psel/penable/pready  task_count register at address 0
//
// For every word the candidate travels one slot cell per cycle down the chain to the result.
// A new word is taken once the previous result is in the output register.
// A stalled result holds the sequencer at the end of its scan until it is taken.
// Reset marks every slot as done and clears the time and the completion count.
`default_nettype none
module preemptive_priority_scheduler_top (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	pps_in_if.sink                      req,
	pps_out_if.source                   res,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [pps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;
	localparam pps_pkg::cnt_t CNT_END = pps_pkg::CNT_W'(pps_pkg::MAX_TASKS);

	logic           state_q;
	pps_pkg::cnt_t  cnt_q;
	logic           cmd_q;
	pps_pkg::tc_t   task_count_q;
	pps_pkg::time_t current_time_q;
	pps_pkg::fc_t   finished_count_q;
	logic           res_v_q;

	pps_pkg::tok_t  tok_w [pps_pkg::MAX_TASKS+1];
	pps_pkg::tok_t  last;
	pps_pkg::ld_t   ld;
	pps_pkg::upd_t  upd;

	logic           accept;
	logic           emit;
	logic           is_tick;
	pps_pkg::time_t rem_dec;
	logic           fin_task;
	pps_pkg::time_t fin;
	pps_pkg::time_t tat;
	pps_pkg::time_t wt;
	logic           all_fin;

	assign pready = 1'b1;
	assign prdata = (paddr[pps_pkg::ADDR_W-1] == pps_pkg::REG_TASK_COUNT) ?
		32'(task_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[pps_pkg::ADDR_W-1] == pps_pkg::REG_TASK_COUNT) begin
			task_count_q <= pwdata[pps_pkg::TC_W-1:0];
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign last      = tok_w[pps_pkg::MAX_TASKS];
	assign is_tick   = (cmd_q == pps_pkg::CMD_TICK);
	assign emit      = (state_q == ST_SCAN) && (cnt_q == CNT_END) && (!res_v_q || res.ready);

	always_comb begin
		ld.valid   = accept && (req.cmd == pps_pkg::CMD_LOAD) && pps_pkg::slot_ok(req.slot);
		ld.slot    = pps_pkg::to_idx(req.slot);
		ld.task_id = req.task_id;
		ld.arrival = pps_pkg::to_time(req.arrival_time);
		ld.burst   = pps_pkg::to_time(req.burst_time);
		if (ld.burst == '0) begin
			ld.burst = pps_pkg::time_t'(1);
		end
		ld.prio    = pps_pkg::to_prio(req.prio_level);
	end

	always_comb begin
		rem_dec  = (last.remaining != '0) ? last.remaining - pps_pkg::time_t'(1) : '0;
		fin_task = last.found && (rem_dec == '0);
		fin      = (current_time_q < pps_pkg::TIME_MAX) ?
			current_time_q + pps_pkg::time_t'(1) : pps_pkg::TIME_MAX;
		tat      = fin - last.arrival;
		wt       = (tat >= last.burst) ? tat - last.burst : '0;
		if (is_tick) begin
			all_fin = (last.pend == 2'd0) || ((last.pend == 2'd1) && fin_task);
		end else begin
			all_fin = (last.pend == 2'd0);
		end
		upd.valid     = emit && is_tick && last.found;
		upd.slot      = last.slot;
		upd.remaining = rem_dec;
		upd.done      = fin_task;
	end

	assign tok_w[0] = '0;

	for (genvar i = 0; i < pps_pkg::MAX_TASKS; i++) begin : g_cell
		pps_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (pps_pkg::idx_t'(i)),
			.tc      (task_count_q),
			.now     (current_time_q),
			.ld      (ld),
			.upd     (upd),
			.tok_in  (tok_w[i]),
			.tok_out (tok_w[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else if (accept) begin
			state_q <= ST_SCAN;
			cnt_q   <= '0;
		end else if (emit) begin
			state_q <= ST_IDLE;
		end else if (state_q == ST_SCAN && cnt_q != CNT_END) begin
			cnt_q <= cnt_q + pps_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_time_q   <= '0;
			finished_count_q <= '0;
		end else if (emit && is_tick) begin
			if (current_time_q < pps_pkg::TIME_MAX) begin
				current_time_q <= current_time_q + pps_pkg::time_t'(1);
			end
			if (fin_task && finished_count_q != pps_pkg::FC_MAX) begin
				finished_count_q <= finished_count_q + pps_pkg::fc_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (emit) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res.now_time        <= pps_pkg::to_ftime(current_time_q);
			res.busy_res        <= is_tick && last.found;
			res.run_slot        <= (is_tick && last.found) ? pps_pkg::to_slot(last.slot) : '0;
			res.run_task_id     <= (is_tick && last.found) ? last.task_id : '0;
			res.task_finished   <= is_tick && fin_task;
			res.finish_time     <= (is_tick && fin_task) ? pps_pkg::to_ftime(fin) : '0;
			res.turnaround_time <= (is_tick && fin_task) ? pps_pkg::to_ftime(tat) : '0;
			res.waiting_time    <= (is_tick && fin_task) ? pps_pkg::to_ftime(wt) : '0;
			res.all_finished    <= all_fin;
		end
	end

	assign res.valid = res_v_q;

endmodule
`default_nettype wire
